// ===== sv/cbd_pkg.sv =====
// Shared types and constants for the circular buffer deque.
`default_nettype none

package cbd_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // result of one operation, carried from the update stage to the output stage
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
    logic             rd_mem;
    logic             nonempty;
  } info_t;

endpackage

`default_nettype wire

// ===== sv/cbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbd_ctrl.sv =====
// Pointer, count and end-value update stage of the deque, issues store accesses.
`default_nettype none

module cbd_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cbd_pkg::OP_W-1:0]      in_op,
  input  wire logic [cbd_pkg::VAL_W-1:0]     in_element_value,
  input  wire logic [cbd_pkg::POS_W-1:0]     in_position,
  input  wire logic                          b_take,
  output logic                               b_valid,
  output cbd_pkg::info_t                     b_info,
  output logic      [DATA_WIDTH-1:0]         cur_front,
  output logic      [DATA_WIDTH-1:0]         cur_back,
  input  wire logic [DATA_WIDTH-1:0]         rd_data,
  output logic                               mem_we,
  output logic      [$clog2(DEPTH)-1:0]      mem_waddr,
  output logic      [DATA_WIDTH-1:0]         mem_wdata,
  output logic                               mem_re,
  output logic      [$clog2(DEPTH)-1:0]      mem_raddr
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + cbd_pkg::CNT_W;
  localparam int PW = CW + cbd_pkg::POS_W;
  localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt, back_r, back_nxt;
  logic front_mem_r, front_mem_nxt, back_mem_r, back_mem_nxt;
  logic b_valid_r, b_valid_nxt;
  cbd_pkg::info_t b_info_r, info_nxt;

  logic accept;
  logic [DATA_WIDTH+cbd_pkg::VAL_W-1:0] val_ext;
  logic [DATA_WIDTH-1:0] val_dw;
  logic [IW-1:0] head_inc, head_dec, tail_inc, tail_dec, rd_idx;
  logic [SW-1:0] sum, sum_wrap;
  logic [PW-1:0] pos_x, cnt_x;
  logic [CW+cbd_pkg::CNT_W-1:0] cnt_ext;
  logic is_empty, is_full, is_last, pos_ge;
  logic we, re, rd_mem;
  cbd_pkg::status_t status;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = b_valid_r & ~b_take;
  assign b_valid  = b_valid_r;
  assign b_info   = b_info_r;

  // true end values: the last read may still sit in the RAM output register
  assign cur_front = front_mem_r ? rd_data : front_r;
  assign cur_back  = back_mem_r ? rd_data : back_r;

  assign val_ext = {{DATA_WIDTH{1'b0}}, in_element_value};
  assign val_dw  = val_ext[DATA_WIDTH-1:0];

  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + IW'(1);
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - IW'(1);
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + IW'(1);
  assign tail_dec = (tail_r == '0) ? LAST_IDX : tail_r - IW'(1);

  assign sum      = {{cbd_pkg::CNT_W{1'b0}}, head_r} + {{IW + 1{1'b0}}, in_position};
  assign sum_wrap = (sum >= DEPTH_SUM) ? sum - DEPTH_SUM : sum;
  assign rd_idx   = sum_wrap[IW-1:0];

  assign pos_x = {{CW{1'b0}}, in_position};
  assign cnt_x = {{cbd_pkg::POS_W{1'b0}}, cnt_r};

  assign is_empty = (cnt_r == '0);
  assign is_full  = (cnt_r == FULL_CNT);
  assign is_last  = (cnt_r == CW'(1));
  assign pos_ge   = (pos_x >= cnt_x);

  always_comb begin
    status        = cbd_pkg::ST_OK;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    front_nxt     = cur_front;
    back_nxt      = cur_back;
    front_mem_nxt = 1'b0;
    back_mem_nxt  = 1'b0;
    rd_mem        = 1'b0;
    we            = 1'b0;
    re            = 1'b0;
    mem_waddr     = tail_r;
    mem_raddr     = head_r;
    unique case (cbd_pkg::op_t'(in_op))
      cbd_pkg::OP_PUSH_BACK, cbd_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          status = cbd_pkg::ST_FULL;
        end else if (is_empty) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          cnt_nxt   = CW'(1);
          we        = 1'b1;
          mem_waddr = '0;
          front_nxt = val_dw;
          back_nxt  = val_dw;
        end else if (cbd_pkg::op_t'(in_op) == cbd_pkg::OP_PUSH_BACK) begin
          tail_nxt  = tail_inc;
          cnt_nxt   = cnt_r + CW'(1);
          we        = 1'b1;
          mem_waddr = tail_inc;
          back_nxt  = val_dw;
        end else begin
          head_nxt  = head_dec;
          cnt_nxt   = cnt_r + CW'(1);
          we        = 1'b1;
          mem_waddr = head_dec;
          front_nxt = val_dw;
        end
      end
      cbd_pkg::OP_POP_BACK, cbd_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          status = cbd_pkg::ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          if (!is_last) begin
            re = 1'b1;
            if (cbd_pkg::op_t'(in_op) == cbd_pkg::OP_POP_BACK) begin
              tail_nxt     = tail_dec;
              mem_raddr    = tail_dec;
              back_mem_nxt = 1'b1;
            end else begin
              head_nxt      = head_inc;
              mem_raddr     = head_inc;
              front_mem_nxt = 1'b1;
            end
          end
        end
      end
      cbd_pkg::OP_READ: begin
        if (is_empty) begin
          status = cbd_pkg::ST_EMPTY;
        end else if (pos_ge) begin
          status = cbd_pkg::ST_RANGE;
        end else begin
          re        = 1'b1;
          rd_mem    = 1'b1;
          mem_raddr = rd_idx;
        end
      end
      default: begin
      end
    endcase

    cnt_ext           = {{cbd_pkg::CNT_W{1'b0}}, cnt_nxt};
    info_nxt.status   = status;
    info_nxt.count    = cnt_ext[cbd_pkg::CNT_W-1:0];
    info_nxt.rd_mem   = rd_mem;
    info_nxt.nonempty = (cnt_nxt != '0);

    b_valid_nxt = accept | (b_valid_r & ~b_take);
  end

  assign mem_we    = accept & we;
  assign mem_re    = accept & re;
  assign mem_wdata = val_dw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      front_mem_r <= 1'b0;
      back_mem_r  <= 1'b0;
      b_valid_r   <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      if (accept) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        cnt_r       <= cnt_nxt;
        front_mem_r <= front_mem_nxt;
        back_mem_r  <= back_mem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      b_info_r <= info_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbd_out.sv =====
// Result register of the deque: resolves end and read values and holds the result.
`default_nettype none

module cbd_out #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        b_valid,
  input  wire cbd_pkg::info_t              b_info,
  input  wire logic [DATA_WIDTH-1:0]       cur_front,
  input  wire logic [DATA_WIDTH-1:0]       cur_back,
  input  wire logic [DATA_WIDTH-1:0]       rd_data,
  output logic                             b_take,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [cbd_pkg::STAT_W-1:0]       out_status,
  output logic [cbd_pkg::CNT_W-1:0]        out_item_count,
  output logic [cbd_pkg::VAL_W-1:0]        out_front_value,
  output logic [cbd_pkg::VAL_W-1:0]        out_back_value,
  output logic [cbd_pkg::VAL_W-1:0]        out_read_value
);

  localparam int XW = DATA_WIDTH + cbd_pkg::VAL_W;

  logic out_valid_r, out_valid_nxt;
  logic load;
  cbd_pkg::status_t status_r;
  logic [cbd_pkg::CNT_W-1:0] count_r;
  logic [cbd_pkg::VAL_W-1:0] front_r, back_r, read_r;
  logic [XW-1:0] front_x, back_x, read_x;

  assign b_take = ~out_valid_r | ~out_stall;
  assign load   = b_valid & b_take;

  assign front_x = {{cbd_pkg::VAL_W{1'b0}}, (b_info.nonempty ? cur_front : '0)};
  assign back_x  = {{cbd_pkg::VAL_W{1'b0}}, (b_info.nonempty ? cur_back : '0)};
  assign read_x  = {{cbd_pkg::VAL_W{1'b0}}, (b_info.rd_mem ? rd_data : '0)};

  always_comb begin
    out_valid_nxt = load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= b_info.status;
      count_r  <= b_info.count;
      front_r  <= front_x[cbd_pkg::VAL_W-1:0];
      back_r   <= back_x[cbd_pkg::VAL_W-1:0];
      read_r   <= read_x[cbd_pkg::VAL_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_item_count  = count_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_read_value  = read_r;

endmodule

`default_nettype wire

// ===== sv/circular_buffer_deque.sv =====
// Each result passes through the update stage register and then the result register.
// Throughput: one operation per cycle; the update stage and the single-read
// store port each take one operation a cycle, and back-pressure holds the input.
// Reset clears head, tail, count and all valid flags; the store is not cleared
// and no entry is read before it has been written.
`default_nettype none

module circular_buffer_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cbd_pkg::OP_W-1:0]      in_op,
  input  wire logic [cbd_pkg::VAL_W-1:0]     in_element_value,
  input  wire logic [cbd_pkg::POS_W-1:0]     in_position,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [cbd_pkg::STAT_W-1:0]         out_status,
  output logic [cbd_pkg::CNT_W-1:0]          out_item_count,
  output logic [cbd_pkg::VAL_W-1:0]          out_front_value,
  output logic [cbd_pkg::VAL_W-1:0]          out_back_value,
  output logic [cbd_pkg::VAL_W-1:0]          out_read_value
);

  localparam int IW = $clog2(DEPTH);
  localparam int FULL_CNT_I = DEPTH % (1 << cbd_pkg::CNT_W);

  logic                  mem_we, mem_re;
  logic [IW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, rd_data;
  logic [DATA_WIDTH-1:0] cur_front, cur_back;
  logic                  b_valid, b_take;
  cbd_pkg::info_t        b_info;

  cbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  cbd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_element_value (in_element_value),
    .in_position      (in_position),
    .b_take           (b_take),
    .b_valid          (b_valid),
    .b_info           (b_info),
    .cur_front        (cur_front),
    .cur_back         (cur_back),
    .rd_data          (rd_data),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr)
  );

  cbd_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .b_valid         (b_valid),
    .b_info          (b_info),
    .cur_front       (cur_front),
    .cur_back        (cur_back),
    .rd_data         (rd_data),
    .b_take          (b_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_item_count  (out_item_count),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_read_value  (out_read_value)
  );

`ifndef SYNTHESIS
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register free");

  a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item_count == '0) |->
      (out_front_value == '0 && out_back_value == '0))
    else $error("end values not zero on empty queue");

  a_failed_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != cbd_pkg::ST_OK) |-> (out_read_value == '0))
    else $error("read value non-zero on failed operation");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cbd_pkg::ST_FULL) |->
      (out_item_count == FULL_CNT_I[cbd_pkg::CNT_W-1:0]))
    else $error("full status without full count");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/deque_result_check.sv =====
// Deque checker: predicts each operation's result and compares result transfers.
module deque_result_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [cbd_pkg::OP_W-1:0]    in_op,
  input  logic [cbd_pkg::VAL_W-1:0]   in_element_value,
  input  logic [cbd_pkg::POS_W-1:0]   in_position,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [cbd_pkg::STAT_W-1:0]  out_status,
  input  logic [cbd_pkg::CNT_W-1:0]   out_item_count,
  input  logic [cbd_pkg::VAL_W-1:0]   out_front_value,
  input  logic [cbd_pkg::VAL_W-1:0]   out_back_value,
  input  logic [cbd_pkg::VAL_W-1:0]   out_read_value,
  output int                          fails,
  output int                          awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbd_pkg::*;

  localparam int DEPTH = 16;
  typedef logic [$clog2(DEPTH)-1:0] idx_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] front;
    logic [VAL_W-1:0] back;
    logic [VAL_W-1:0] rd;
  } deque_result_t;

  logic [VAL_W-1:0] store [DEPTH];
  idx_t             head;
  idx_t             tail;
  logic [CNT_W-1:0] count;
  deque_result_t    expected_q [$];
  int               err_count = 0;

  assign fails = err_count;

  function automatic idx_t step_up(input idx_t i);
    return (int'(i) == DEPTH - 1) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t step_down(input idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

  function automatic deque_result_t apply_op(input logic [OP_W-1:0] op,
                                             input logic [VAL_W-1:0] val,
                                             input logic [POS_W-1:0] pos);
    deque_result_t r;
    r = '0;
    r.status = ST_OK;
    case (op_t'(op))
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (int'(count) >= DEPTH) begin
          r.status = ST_FULL;
        end else if (count == '0) begin
          head = '0;
          tail = '0;
          store[0] = val;
          count = CNT_W'(1);
        end else if (op_t'(op) == OP_PUSH_BACK) begin
          tail = step_up(tail);
          store[tail] = val;
          count = count + 1'b1;
        end else begin
          head = step_down(head);
          store[head] = val;
          count = count + 1'b1;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (count == '0) begin
          r.status = ST_EMPTY;
        end else begin
          // last entry leaves the indices where they are
          if (count > 1) begin
            if (op_t'(op) == OP_POP_BACK) tail = step_down(tail);
            else head = step_up(head);
          end
          count = count - 1'b1;
        end
      end
      OP_READ: begin
        if (count == '0) r.status = ST_EMPTY;
        else if (pos >= count) r.status = ST_RANGE;
        else r.rd = store[idx_t'((int'(head) + int'(pos)) % DEPTH)];
      end
      default: ;
    endcase
    r.count = count;
    if (count != '0) begin
      r.front = store[head];
      r.back  = store[tail];
    end
    return r;
  endfunction

  task automatic compare(input string field, input logic [VAL_W-1:0] want,
                         input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : track
    deque_result_t want;
    if (!rst_n) begin
      head = '0;
      tail = '0;
      count = '0;
      expected_q.delete();
      awaiting <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no operation outstanding");
          err_count++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          compare("status", want.status, out_status);
          compare("item_count", want.count, out_item_count);
          compare("front_value", want.front, out_front_value);
          compare("back_value", want.back, out_back_value);
          compare("read_value", want.rd, out_read_value);
        end
      end
      if (in_valid && !in_stall)
        expected_q = {expected_q, apply_op(in_op, in_element_value, in_position)};
      awaiting <= expected_q.size();
    end
  end

endmodule

// ===== tb/sv/circular_buffer_deque_tb.sv =====
// Testbench top: drives deque operations with random gaps and stalls, gives the verdict.
module circular_buffer_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbd_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_READ} phase_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_op = '0;
  logic [VAL_W-1:0]   in_element_value = '0;
  logic [POS_W-1:0]   in_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  out_status;
  logic [CNT_W-1:0]   out_item_count;
  logic [VAL_W-1:0]   out_front_value;
  logic [VAL_W-1:0]   out_back_value;
  logic [VAL_W-1:0]   out_read_value;
  int                 fails;
  int                 awaiting;
  bit                 calm = 1'b0;
  int unsigned        rx_hold = 0;
  int unsigned        cycle_count = 0;

  always #1 clk = ~clk;

  circular_buffer_deque dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_element_value (in_element_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_item_count   (out_item_count),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_read_value   (out_read_value)
  );

  deque_result_check u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_element_value (in_element_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_item_count   (out_item_count),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_read_value   (out_read_value),
    .fails            (fails),
    .awaiting         (awaiting)
  );

  function automatic int unsigned draw_wait();
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
  endfunction

  // valid stays high across back-to-back transfers
  task automatic send_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                         input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_element_value <= val;
    in_position      <= pos;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin : rx_side
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= (rx_hold != 1);
    end else if (out_valid && !out_stall) begin
      n = draw_wait();
      rx_hold   <= n;
      out_stall <= (n != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      len;
    int unsigned      roll;
    int unsigned      push_w;
    int unsigned      pop_w;
    int               done;
    phase_t           bias;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue
    send_op(OP_POP_BACK, '0, '0);
    send_op(OP_POP_FRONT, '1, '1);
    send_op(OP_READ, '0, '0);
    send_op(OP_READ, '1, '1);
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
      send_op(OP_W'(c), 32'hA5A5_5A5A, '0);
    // both ends, reads in and out of range
    send_op(OP_PUSH_BACK, '0, '0);
    send_op(OP_PUSH_FRONT, '1, '0);
    send_op(OP_READ, '0, 4'd0);
    send_op(OP_READ, '0, 4'd1);
    send_op(OP_READ, '0, 4'd2);
    send_op(OP_READ, '0, 4'd15);
    send_op(OP_SPARE_LAST, '1, '1);
    send_op(OP_POP_BACK, '0, '0);
    send_op(OP_POP_FRONT, '0, '0);
    send_op(OP_POP_FRONT, '0, '0);

    done = 0;
    while (done < RANDOM_ITEMS) begin
      len  = $urandom_range(20, 60);
      bias = phase_t'($urandom_range(0, 3));
      calm = ($urandom_range(0, 3) == 0);
      case (bias)
        PH_FILL: begin
          push_w = 75;
          pop_w  = 15;
        end
        PH_DRAIN: begin
          push_w = 15;
          pop_w  = 75;
        end
        PH_MIXED: begin
          push_w = 40;
          pop_w  = 40;
        end
        default: begin
          push_w = 30;
          pop_w  = 20;
        end
      endcase
      for (int k = 0; k < len && done < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_w) op = roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (roll < push_w + pop_w) op = roll[0] ? OP_POP_FRONT : OP_POP_BACK;
        else op = OP_READ;
        case ($urandom_range(0, 9))
          0: val = '0;
          1: val = '1;
          default: val = $urandom();
        endcase
        send_op(op, val, POS_W'($urandom_range(0, 15)));
        done++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (awaiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
